>>> hw/rtl/pausable_stopwatch_with_stats_top_macros.svh
// Assertion helpers shared by the stopwatch RTL.
// Each macro checks a property on the rising clock edge and is disabled during reset.
`ifndef PAUSABLE_STOPWATCH_WITH_STATS_TOP_MACROS_SVH
`define PAUSABLE_STOPWATCH_WITH_STATS_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSWS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/psws_pkg.sv
`default_nettype none

package psws_pkg;

  // Event codes carried in the action field.
  localparam logic [2:0] ACT_START  = 3'd0;
  localparam logic [2:0] ACT_PAUSE  = 3'd1;
  localparam logic [2:0] ACT_RESUME = 3'd2;
  localparam logic [2:0] ACT_END    = 3'd3;
  localparam logic [2:0] ACT_LOAD   = 3'd4;
  localparam logic [2:0] ACT_QUERY  = 3'd5;

  // Run state of the stopwatch.
  typedef enum logic [1:0] {
    RUN_STOPPED = 2'd0,
    RUN_RUNNING = 2'd1,
    RUN_PAUSED  = 2'd2
  } psws_run_e;

  // Event sequencer of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_MEAN,
    ST_OVERALL,
    ST_EMIT
  } psws_state_e;

  // Phases of the iterative mean unit.
  typedef enum logic [2:0] {
    MU_IDLE,
    MU_MUL,
    MU_ADD,
    MU_DIV,
    MU_DONE
  } psws_mu_state_e;

  // One input event.
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now;
    logic [31:0] trigger;
  } psws_in_t;

  // One result per event.
  typedef struct packed {
    logic [1:0]  run_status;
    logic [31:0] overall;
    logic [31:0] remaining;
    logic [31:0] last_time;
    logic [31:0] mean_time;
    logic [31:0] highest_time;
    logic [31:0] lowest_time;
    logic        window_done;
  } psws_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/psws_mean_unit.sv
`default_nettype none

// Iterative running-mean update: (mean * (n - 1) + dur) / n.
// A single adder serves a shift-add multiply, the addition of the new
// duration and a restoring division, one step per cycle.
module psws_mean_unit import psws_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [TIME_WIDTH-1:0] mean_i,
  input  wire logic [TIME_WIDTH-1:0] dur_i,
  input  wire logic [15:0]           count_i,
  output logic                       done_o,
  output logic [TIME_WIDTH-1:0]      mean_o
);

  // The product plus one duration needs 16 + 1 bits above the time width.
  localparam int AccW = TIME_WIDTH + 17;
  localparam int CntW = $clog2(TIME_WIDTH);

  psws_mu_state_e state_q, state_d;

  logic [AccW-1:0]       acc_q;
  logic [AccW-1:0]       mcand_q;
  logic [15:0]           mplier_q;
  logic [TIME_WIDTH-1:0] dur_q;
  logic [15:0]           count_q;
  logic [15:0]           rem_q;
  logic [TIME_WIDTH-1:0] quo_q;
  logic [CntW-1:0]       cnt_q;

  logic [AccW-1:0] add_a;
  logic [AccW-1:0] add_b;
  logic            add_sub;
  logic [AccW-1:0] sum;
  logic [16:0]     trial;
  logic            neg;

  // Shared adder; subtraction by inverting the second operand.
  assign sum   = add_a + (add_sub ? ~add_b : add_b) + AccW'(add_sub);
  assign trial = {rem_q, quo_q[TIME_WIDTH-1]};
  assign neg   = sum[AccW-1];

  // Phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next phase.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MU_IDLE: begin
        if (start_i) state_d = MU_MUL;
      end
      MU_MUL: begin
        if (mplier_q == '0) state_d = MU_ADD;
      end
      MU_ADD: begin
        state_d = MU_DIV;
      end
      MU_DIV: begin
        if (cnt_q == '0) state_d = MU_DONE;
      end
      MU_DONE: begin
        state_d = MU_IDLE;
      end
      default: begin
        state_d = MU_IDLE;
      end
    endcase
  end

  // Adder operand selection for each phase.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    done_o  = 1'b0;
    unique case (state_q)
      MU_MUL: begin
        add_a = acc_q;
        add_b = mcand_q;
      end
      MU_ADD: begin
        add_a = acc_q;
        add_b = AccW'(dur_q);
      end
      MU_DIV: begin
        add_a   = AccW'(trial);
        add_b   = AccW'(count_q);
        add_sub = 1'b1;
      end
      MU_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MU_IDLE: begin
        if (start_i) begin
          acc_q    <= '0;
          mcand_q  <= AccW'(mean_i);
          mplier_q <= count_i - 16'd1;
          dur_q    <= dur_i;
          count_q  <= count_i;
        end
      end
      MU_MUL: begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) acc_q <= sum;
          mcand_q  <= {mcand_q[AccW-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[15:1]};
        end
      end
      MU_ADD: begin
        // The dividend is below count * 2^TIME_WIDTH, so its upper part fits the remainder.
        rem_q <= sum[TIME_WIDTH+15:TIME_WIDTH];
        quo_q <= sum[TIME_WIDTH-1:0];
        cnt_q <= CntW'(TIME_WIDTH - 1);
      end
      MU_DIV: begin
        rem_q <= neg ? trial[15:0] : sum[15:0];
        quo_q <= {quo_q[TIME_WIDTH-2:0], ~neg};
        cnt_q <= cnt_q - CntW'(1);
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign mean_o = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/pausable_stopwatch_with_stats_top.sv
`default_nettype none

// Event-driven stopwatch with windowed duration statistics. Each accepted event
// (start, pause, resume, end, load countdown, query) yields exactly one result with
// the run state, the overall elapsed time, the countdown time left, the last
// measured duration and the latched window mean, maximum and minimum. Events are
// handled one at a time: each passes the apply, overall and emit steps, and the
// next event can be taken once its result is loaded into the output register, which
// a stall on the output can hold off. An end event also runs the shared-adder mean
// unit between apply and overall unless the window index wraps to zero; the unit
// does its multiply, one add and a division that yields one quotient bit per cycle.
// window_count is written through the configuration channel, which is always
// ready; write it only while no event is in flight.
`include "pausable_stopwatch_with_stats_top_macros.svh"

module pausable_stopwatch_with_stats_top import psws_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire psws_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output psws_out_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  psws_state_e state_q, state_d;

  // Captured event.
  logic [2:0]            act_q;
  logic [TIME_WIDTH-1:0] t_q;
  logic [TIME_WIDTH-1:0] trig_q;

  // Stopwatch and statistics state.
  psws_run_e             run_q;
  logic                  ever_q;
  logic [TIME_WIDTH-1:0] start_q;
  logic [TIME_WIDTH-1:0] paused_q;
  logic [TIME_WIDTH-1:0] cdown_q;
  logic [15:0]           idx_q;
  logic [TIME_WIDTH-1:0] wmin_q;
  logic [TIME_WIDTH-1:0] wmax_q;
  logic [TIME_WIDTH-1:0] wmean_q;
  logic [TIME_WIDTH-1:0] last_q;
  logic [TIME_WIDTH-1:0] hmean_q;
  logic [TIME_WIDTH-1:0] hmax_q;
  logic [TIME_WIDTH-1:0] hmin_q;
  logic [TIME_WIDTH-1:0] overall_q;
  logic                  wdone_q;
  logic [15:0]           wcount_q;

  logic      out_valid_q;
  psws_out_t out_data_q;

  logic                  in_stall;
  logic                  mu_start;
  logic                  emit_load;
  logic                  mu_done;
  logic [TIME_WIDTH-1:0] mu_mean;
  logic [TIME_WIDTH-1:0] elapsed_w;
  logic [TIME_WIDTH-1:0] dur_w;
  logic [TIME_WIDTH-1:0] overall_w;
  logic [TIME_WIDTH:0]   diff_w;
  logic [TIME_WIDTH-1:0] remain_w;
  logic [15:0]           idx_inc_w;

  // Time arithmetic, all modulo 2^TIME_WIDTH.
  assign elapsed_w = t_q - start_q + paused_q;
  assign dur_w     = (run_q == RUN_PAUSED) ? paused_q : elapsed_w;
  assign idx_inc_w = idx_q + 16'd1;

  always_comb begin
    if (run_q == RUN_PAUSED) begin
      overall_w = paused_q;
    end else if (ever_q) begin
      overall_w = elapsed_w;
    end else begin
      overall_w = '0;
    end
  end

  // Countdown time left; zero while stopped or once overall reaches the countdown length.
  assign diff_w   = {1'b0, cdown_q} - {1'b0, overall_q};
  assign remain_w = ((run_q == RUN_STOPPED) || diff_w[TIME_WIDTH] ||
                     (diff_w[TIME_WIDTH-1:0] == '0)) ? '0 : diff_w[TIME_WIDTH-1:0];

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if ((act_q == ACT_END) && (idx_inc_w != '0)) begin
          state_d = ST_MEAN;
        end else begin
          state_d = ST_OVERALL;
        end
      end
      ST_MEAN: begin
        if (mu_done) state_d = ST_OVERALL;
      end
      ST_OVERALL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    mu_start  = 1'b0;
    emit_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_APPLY: begin
        mu_start = (act_q == ACT_END) && (idx_inc_w != '0);
      end
      ST_EMIT: begin
        emit_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_stall_o  = in_stall;
  assign cfg_ready_o = 1'b1;

  // Capture the event on its transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall) begin
      act_q  <= in_data_i.action;
      t_q    <= TIME_WIDTH'(in_data_i.now);
      trig_q <= TIME_WIDTH'(in_data_i.trigger);
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q <= 16'd1;
    end else if (cfg_valid_i) begin
      wcount_q <= cfg_data_i;
    end
  end

  // Event handling, mean update and window latch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= RUN_STOPPED;
      ever_q    <= 1'b0;
      start_q   <= '0;
      paused_q  <= '0;
      cdown_q   <= '0;
      idx_q     <= '0;
      wmin_q    <= '1;
      wmax_q    <= '0;
      wmean_q   <= '0;
      last_q    <= '0;
      hmean_q   <= '0;
      hmax_q    <= '0;
      hmin_q    <= '0;
      overall_q <= '0;
      wdone_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_APPLY: begin
          unique case (act_q)
            ACT_START: begin
              start_q  <= t_q;
              paused_q <= '0;
              run_q    <= RUN_RUNNING;
              ever_q   <= 1'b1;
            end
            ACT_LOAD: begin
              start_q  <= t_q;
              paused_q <= '0;
              run_q    <= RUN_RUNNING;
              ever_q   <= 1'b1;
              cdown_q  <= trig_q;
            end
            ACT_PAUSE: begin
              if (run_q == RUN_RUNNING) begin
                paused_q <= elapsed_w;
                run_q    <= RUN_PAUSED;
              end
            end
            ACT_RESUME: begin
              if (run_q == RUN_PAUSED) begin
                start_q <= t_q;
                run_q   <= RUN_RUNNING;
              end
            end
            ACT_END: begin
              run_q  <= RUN_STOPPED;
              idx_q  <= idx_inc_w;
              last_q <= dur_w;
              if (wmax_q < dur_w) wmax_q <= dur_w;
              if (wmin_q > dur_w) wmin_q <= dur_w;
            end
            default: begin
              run_q <= run_q;
            end
          endcase
        end
        ST_MEAN: begin
          if (mu_done) wmean_q <= mu_mean;
        end
        ST_OVERALL: begin
          overall_q <= overall_w;
          wdone_q   <= 1'b0;
          // A full window moves its results to the held values and restarts.
          if ((act_q == ACT_END) && (idx_q >= wcount_q)) begin
            hmean_q <= wmean_q;
            hmax_q  <= wmax_q;
            hmin_q  <= wmin_q;
            wmin_q  <= '1;
            wmax_q  <= '0;
            wmean_q <= '0;
            idx_q   <= '0;
            wdone_q <= 1'b1;
          end
        end
        default: begin
          wdone_q <= wdone_q;
        end
      endcase
    end
  end

  psws_mean_unit #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mu_start),
    .mean_i  (wmean_q),
    .dur_i   (dur_w),
    .count_i (idx_inc_w),
    .done_o  (mu_done),
    .mean_o  (mu_mean)
  );

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_data_q.run_status   <= run_q;
      out_data_q.overall      <= 32'(overall_q);
      out_data_q.remaining    <= 32'(remain_w);
      out_data_q.last_time    <= 32'(last_q);
      out_data_q.mean_time    <= 32'(hmean_q);
      out_data_q.highest_time <= 32'(hmax_q);
      out_data_q.lowest_time  <= 32'(hmin_q);
      out_data_q.window_done  <= wdone_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted event always enters the apply step next.
  `PSWS_ASSERT_NXT(a_accept_apply, clk_i, rst_ni, in_valid_i && !in_stall, state_q == ST_APPLY, "event transfer did not lead to apply step")
  // The mean unit only finishes while the sequencer waits for it.
  `PSWS_ASSERT_IMP(a_mean_done_wait, clk_i, rst_ni, mu_done, state_q == ST_MEAN, "mean unit finished outside mean step")
  // A nonempty window always has its minimum at or below its maximum.
  `PSWS_ASSERT_IMP(a_window_order, clk_i, rst_ni, (state_q == ST_IDLE) && (idx_q != '0), wmin_q <= wmax_q, "window minimum above maximum")
  // Only an end event can complete a window.
  `PSWS_ASSERT_IMP(a_done_on_end, clk_i, rst_ni, emit_load && wdone_q, act_q == ACT_END, "window completed by an event other than end")

endmodule

`default_nettype wire

>>> bench/pausable_stopwatch_with_stats_top_tb.sv
module pausable_stopwatch_with_stats_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psws_pkg::*;

  // Tracks the stopwatch state and holds the results that are still owed.
  class stopwatch_tracker;
    logic [15:0] window_count     = 16'd1;
    psws_run_e   run_state        = RUN_STOPPED;
    bit          ever_started     = 1'b0;
    logic [31:0] start_stamp      = '0;
    logic [31:0] paused_total     = '0;
    logic [31:0] countdown_length = '0;
    logic [15:0] window_index     = '0;
    logic [31:0] window_min       = '1;
    logic [31:0] window_max       = '0;
    logic [31:0] window_mean      = '0;
    logic [31:0] last_duration    = '0;
    logic [31:0] held_mean        = '0;
    logic [31:0] held_max         = '0;
    logic [31:0] held_min         = '0;
    psws_out_t   expected_results[$];
    int          errors;
    int          results_seen;

    // Time since the last start stamp plus the time banked before a pause.
    function logic [31:0] elapsed_at(logic [31:0] stamp);
      return stamp - start_stamp + paused_total;
    endfunction

    function void begin_run(logic [31:0] stamp);
      start_stamp  = stamp;
      paused_total = '0;
      run_state    = RUN_RUNNING;
      ever_started = 1'b1;
    endfunction

    // Applies one accepted event and queues the result it must produce.
    function void note_event(psws_in_t ev);
      psws_out_t   res;
      logic [31:0] dur;
      logic [63:0] sum;
      res = '0;
      case (ev.action)
        ACT_START: begin
          begin_run(ev.now);
        end
        ACT_PAUSE: begin
          if (run_state == RUN_RUNNING) begin
            paused_total = elapsed_at(ev.now);
            run_state    = RUN_PAUSED;
          end
        end
        ACT_RESUME: begin
          if (run_state == RUN_PAUSED) begin
            start_stamp = ev.now;
            run_state   = RUN_RUNNING;
          end
        end
        ACT_END: begin
          // Ending while paused measures only the banked time.
          dur = (run_state == RUN_PAUSED) ? paused_total : elapsed_at(ev.now);
          run_state = RUN_STOPPED;
          window_index = window_index + 16'd1;
          if (window_index != 16'd0) begin
            sum = {32'd0, window_mean} * {48'd0, window_index - 16'd1} + {32'd0, dur};
            window_mean = 32'(sum / {48'd0, window_index});
          end
          if (window_max < dur) window_max = dur;
          if (window_min > dur) window_min = dur;
          last_duration = dur;
          // A count at or below the index latches the window, zero included.
          if (window_index >= window_count) begin
            held_mean       = window_mean;
            held_max        = window_max;
            held_min        = window_min;
            window_index    = '0;
            window_min      = '1;
            window_max      = '0;
            window_mean     = '0;
            res.window_done = 1'b1;
          end
        end
        ACT_LOAD: begin
          begin_run(ev.now);
          countdown_length = ev.trigger;
        end
        default: begin
        end
      endcase

      res.run_status = run_state;
      if (run_state == RUN_PAUSED) begin
        res.overall = paused_total;
      end else if (ever_started) begin
        res.overall = elapsed_at(ev.now);
      end else begin
        res.overall = '0;
      end
      if (run_state == RUN_STOPPED || res.overall >= countdown_length) begin
        res.remaining = '0;
      end else begin
        res.remaining = countdown_length - res.overall;
      end
      res.last_time    = last_duration;
      res.mean_time    = held_mean;
      res.highest_time = held_max;
      res.lowest_time  = held_min;
      expected_results.push_back(res);
    endfunction

    task report(string what);
      $display("MISMATCH at result %0d: %s", results_seen, what);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s is %h, expected %h", name, got, want));
      end
    endtask

    // Compares one result transfer against the oldest queued result.
    task check_result(psws_out_t got);
      psws_out_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("result arrived with no event outstanding");
        return;
      end
      want = expected_results.pop_front();
      compare_field("run_status", got.run_status, want.run_status);
      compare_field("overall", got.overall, want.overall);
      compare_field("remaining", got.remaining, want.remaining);
      compare_field("last_time", got.last_time, want.last_time);
      compare_field("mean_time", got.mean_time, want.mean_time);
      compare_field("highest_time", got.highest_time, want.highest_time);
      compare_field("lowest_time", got.lowest_time, want.lowest_time);
      compare_field("window_done", got.window_done, want.window_done);
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  psws_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  psws_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  stopwatch_tracker board = new();

  bit          idle_en;
  bit          hold_request;
  bit          valid_shadow;
  int          items_sent;
  logic [31:0] wall = '0;

  pausable_stopwatch_with_stats_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offers one event and waits for its transfer, then maybe leaves a gap.
  task automatic send_event(logic [2:0] action, logic [31:0] stamp, logic [31:0] trig);
    psws_in_t ev;
    ev.action  = action;
    ev.now     = stamp;
    ev.trigger = trig;
    in_valid_i   <= 1'b1;
    in_data_i    <= ev;
    valid_shadow = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_event(ev);
    items_sent++;
    if (idle_en && $urandom_range(0, 99) < 25) begin
      in_valid_i   <= 1'b0;
      valid_shadow = 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every owed result has been taken.
  task automatic drain();
    if (valid_shadow) begin
      in_valid_i   <= 1'b0;
      valid_shadow = 1'b0;
    end
    while (board.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window_count(logic [15:0] count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.window_count = count;
  endtask

  // Wall clock that mostly creeps forward and now and then jumps anywhere.
  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 99) < 5) begin
      wall = $urandom;
    end else begin
      wall = wall + $urandom_range(0, 300);
    end
    return wall;
  endfunction

  // One start or load, a few pause, resume and query events, then an end.
  task automatic run_measurement();
    logic [31:0] trig;
    if ($urandom_range(0, 1) == 0) begin
      send_event(ACT_START, next_stamp(), $urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: trig = '0;
        1: trig = '1;
        2: trig = $urandom_range(0, 2000);
        default: trig = $urandom;
      endcase
      send_event(ACT_LOAD, next_stamp(), trig);
    end
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_event(ACT_PAUSE, next_stamp(), $urandom);
        3, 4, 5: send_event(ACT_RESUME, next_stamp(), $urandom);
        default: send_event(ACT_QUERY, next_stamp(), $urandom);
      endcase
    end
    send_event(ACT_END, next_stamp(), $urandom);
  endtask

  // A stretch of random traffic under one window count.
  task automatic random_phase(logic [15:0] count, bit quiet, bit squeeze, int amount);
    int stop_at;
    drain();
    write_window_count(count);
    idle_en = !quiet;
    if (squeeze) hold_request = 1'b1;
    stop_at = items_sent + amount;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        run_measurement();
      end else begin
        send_event(3'($urandom_range(0, 7)), $urandom, $urandom);
      end
    end
  endtask

  // Result side: checks each transfer and picks the stall for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      if (hold_request) begin
        hold_left    = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(0, 99) < 20);
      end
    end
  end

  // Event side: directed cases, window count corners, then random phases.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_window_count(16'd1);
    idle_en = 1'b1;

    // Queries and ends before any start, and ignored pause and resume.
    send_event(ACT_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
    send_event(ACT_END, 32'hFFFF_FFFF, 32'h0000_0000);
    send_event(ACT_PAUSE, 32'd5, 32'd0);
    send_event(ACT_RESUME, 32'd6, 32'd0);
    // A run that wraps the time stamp and ends while paused.
    send_event(ACT_START, 32'hFFFF_FFF0, 32'd0);
    send_event(ACT_QUERY, 32'h0000_0010, 32'd0);
    send_event(ACT_PAUSE, 32'd20, 32'd0);
    send_event(ACT_RESUME, 32'd100, 32'd0);
    send_event(ACT_PAUSE, 32'd150, 32'd0);
    send_event(ACT_END, 32'd300, 32'd0);
    // Countdowns at the extremes, then one that runs out.
    send_event(ACT_LOAD, 32'd0, 32'hFFFF_FFFF);
    send_event(ACT_QUERY, 32'd1000, 32'd0);
    send_event(ACT_LOAD, 32'd2000, 32'd0);
    send_event(ACT_QUERY, 32'd2500, 32'd0);
    send_event(ACT_LOAD, 32'd3000, 32'd500);
    send_event(ACT_QUERY, 32'd3400, 32'd0);
    send_event(ACT_QUERY, 32'd3600, 32'd0);
    // Unused codes behave as queries.
    send_event(3'd6, 32'd3700, 32'hFFFF_FFFF);
    send_event(3'd7, 32'd3800, 32'hFFFF_FFFF);
    // End while running; the overall time keeps counting afterwards.
    send_event(ACT_END, 32'd4000, 32'd0);
    send_event(ACT_QUERY, 32'd4100, 32'd0);
    send_event(ACT_RESUME, 32'd4200, 32'd0);

    // Lowering the window count below the current index latches on the next end.
    drain();
    write_window_count(16'd5);
    repeat (3) begin
      send_event(ACT_START, next_stamp(), 32'd0);
      send_event(ACT_END, next_stamp(), 32'd0);
    end
    drain();
    write_window_count(16'd2);
    send_event(ACT_START, next_stamp(), 32'd0);
    send_event(ACT_END, next_stamp(), 32'd0);
    // A window count of zero latches on every end.
    drain();
    write_window_count(16'd0);
    send_event(ACT_END, next_stamp(), 32'd0);
    send_event(ACT_END, next_stamp(), 32'd0);

    random_phase(16'd3, 1'b0, 1'b0, 100);
    random_phase(16'd65535, 1'b1, 1'b0, 100);
    random_phase(16'd1, 1'b0, 1'b1, 100);
    random_phase(16'd0, 1'b0, 1'b0, 60);
    random_phase(16'($urandom_range(2, 12)), 1'b0, 1'b1, 120);
    random_phase(16'd7, 1'b0, 1'b0, 120);

    drain();
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
